@@ rtl/core/lru_key_index_table_unit_assert.svh @@
// Assertion macros used by the key index table controller.
`ifndef LRU_KEY_INDEX_TABLE_UNIT_ASSERT_SVH
`define LRU_KEY_INDEX_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LKIT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkit: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LKIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkit: assertion failed");

`endif

@@ rtl/core/lkit_pkg.sv @@
// Package with sizes, codes, structs and helpers for the key index table.
package lkit_pkg;

  // Table geometry.
  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 64;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int STAMP_W  = 48;

  // Fixed port field widths.
  localparam int KEY_PORT_W  = 64;
  localparam int SLOT_PORT_W = 6;
  localparam int STATUS_W    = 3;
  localparam int CAP_W       = 7;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_FREE     = 3'd1,
    ST_REPLACED = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } ctrl_state_t;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic               have_lru;
    logic [SLOT_W-1:0]  lru;
    logic [STAMP_W-1:0] lru_stamp;
  } scan_pkt_t;

  // Update broadcast to all cells; only the addressed cell takes it.
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic                load_key;
    logic [KEY_BITS-1:0] key;
    logic                pin;
    logic [STAMP_W-1:0]  stamp;
  } wr_cmd_t;

  // Slot number as reported on the port: low six bits, zero-extended if narrower.
  function automatic logic [SLOT_PORT_W-1:0] slot_port(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+SLOT_PORT_W-1:0] wide;
    wide = (SLOT_W + SLOT_PORT_W)'(slot);
    return wide[SLOT_PORT_W-1:0];
  endfunction

endpackage

@@ rtl/core/lkit_req_if.sv @@
// Request channel: one lookup or define beat.
interface lkit_req_if import lkit_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_PORT_W-1:0] key;
  logic                  sticky;

  modport source (output valid, mode, key, sticky, input ready);
  modport sink   (input valid, mode, key, sticky, output ready);
endinterface

@@ rtl/core/lkit_rsp_if.sv @@
// Response channel: slot index and status of one request.
interface lkit_rsp_if import lkit_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [SLOT_PORT_W-1:0] slot_index;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, slot_index, status, input ready);
  modport sink   (input valid, slot_index, status, output ready);
endinterface

@@ rtl/core/lkit_cfg_if.sv @@
// Configuration write channel for the capacity register.
interface lkit_cfg_if import lkit_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

@@ rtl/core/lkit_cell.sv @@
// One table slot: holds key, pin and stamp, and updates the passing search token.
module lkit_cell import lkit_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [SLOT_W-1:0]   idx,
  input  logic [CNT_W-1:0]    filled,
  input  logic [KEY_BITS-1:0] qkey,
  input  wr_cmd_t             cmd,
  input  scan_pkt_t           pkt_in,
  output scan_pkt_t           pkt_out
);

  logic [KEY_BITS-1:0] key;
  logic                pinned;
  logic [STAMP_W-1:0]  stamp;
  logic                live;
  scan_pkt_t           pkt_next;

  // Only filled slots take part in the search.
  assign live = CNT_W'(idx) < filled;

  // First match wins; the oldest unpinned stamp wins, lowest slot on a tie.
  always_comb begin
    pkt_next = pkt_in;
    if (!pkt_in.found && live && key == qkey) begin
      pkt_next.found = 1'b1;
      pkt_next.slot  = idx;
    end
    if (live && !pinned && (!pkt_in.have_lru || stamp < pkt_in.lru_stamp)) begin
      pkt_next.have_lru  = 1'b1;
      pkt_next.lru       = idx;
      pkt_next.lru_stamp = stamp;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out.valid <= pkt_in.valid;
    end
    pkt_out.found     <= pkt_next.found;
    pkt_out.slot      <= pkt_next.slot;
    pkt_out.have_lru  <= pkt_next.have_lru;
    pkt_out.lru       <= pkt_next.lru;
    pkt_out.lru_stamp <= pkt_next.lru_stamp;
  end

  // Pin flag: cleared at reset, set or reloaded by an update to this slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      pinned <= 1'b0;
    end else if (cmd.en && cmd.slot == idx) begin
      pinned <= cmd.load_key ? cmd.pin : (pinned | cmd.pin);
    end
  end

  // Key and recency stamp.
  always_ff @(posedge clk) begin
    if (cmd.en && cmd.slot == idx) begin
      stamp <= cmd.stamp;
      if (cmd.load_key) begin
        key <= cmd.key;
      end
    end
  end

endmodule

@@ rtl/core/lkit_ctrl.sv @@
// Sequencer: takes requests, launches the scan, decides and issues the update.
module lkit_ctrl import lkit_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  lkit_req_if.sink            req,
  lkit_rsp_if.source          rsp,
  lkit_cfg_if.sink            cfg,
  output scan_pkt_t           inject,
  input  scan_pkt_t           tail,
  output logic [KEY_BITS-1:0] qkey,
  output logic [CNT_W-1:0]    slots_filled,
  output wr_cmd_t             cmd
);

`include "lru_key_index_table_unit_assert.svh"

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [CAP_W-1:0]     capacity;
  logic                 req_mode;
  logic                 req_sticky;
  logic                 inject_valid;
  scan_pkt_t            res;
  logic [STAMP_W-1:0]   global_stamp;
  logic [STAMP_W-1:0]   stamp_inc;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_eff;
  logic                 has_room;
  logic                 accept;
  logic                 capture;
  logic                 commit;
  status_t              dec_status;
  logic [SLOT_W-1:0]    dec_slot;
  logic                 dec_write;
  logic                 dec_load_key;

  assign cfg.ready = !rst;
  assign stamp_inc = global_stamp + STAMP_W'(1);

  // Capacity limited to the table size, then compared with the fill count.
  assign cap_ext  = CMP_W'(capacity);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign has_room = CMP_W'(slots_filled) < cap_eff;

  // Token entering the first cell.
  always_comb begin
    inject           = '0;
    inject.valid     = inject_valid;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req.valid) state_next = S_SCAN;
      S_SCAN:   if (tail.valid) state_next = S_DECIDE;
      S_DECIDE: if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    req.ready = 1'b0;
    capture   = 1'b0;
    commit    = 1'b0;
    case (state)
      S_IDLE:   req.ready = !rst;
      S_SCAN:   capture   = tail.valid;
      S_DECIDE: commit    = !rsp.valid || rsp.ready;
      default:  req.ready = 1'b0;
    endcase
  end

  assign accept = req.valid && req.ready;

  // Outcome of the finished scan.
  always_comb begin
    dec_status   = ST_FULL;
    dec_slot     = '0;
    dec_write    = 1'b0;
    dec_load_key = 1'b0;
    if (res.found) begin
      dec_status = ST_HIT;
      dec_slot   = res.slot;
      dec_write  = 1'b1;
    end else if (!req_mode) begin
      dec_status = ST_MISS;
    end else if (has_room) begin
      dec_status   = ST_FREE;
      dec_slot     = slots_filled[SLOT_W-1:0];
      dec_write    = 1'b1;
      dec_load_key = 1'b1;
    end else if (res.have_lru) begin
      dec_status   = ST_REPLACED;
      dec_slot     = res.lru;
      dec_write    = 1'b1;
      dec_load_key = 1'b1;
    end
  end

  // Control registers and the update broadcast to the cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      capacity     <= CAP_RESET;
      inject_valid <= 1'b0;
      slots_filled <= '0;
      global_stamp <= '0;
      cmd.en       <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      state        <= state_next;
      inject_valid <= accept;
      cmd.en       <= commit && dec_write;
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.capacity_in_use;
      end
      if (commit && dec_write) begin
        global_stamp <= stamp_inc;
      end
      if (commit && dec_status == ST_FREE) begin
        slots_filled <= slots_filled + CNT_W'(1);
      end
      if (commit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (commit) begin
      cmd.slot     <= dec_slot;
      cmd.load_key <= dec_load_key;
      cmd.key      <= qkey;
      cmd.pin      <= req_mode && req_sticky;
      cmd.stamp    <= stamp_inc;
    end
  end

  // Request, scan result and response payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode   <= req.mode;
      req_sticky <= req.sticky;
      qkey       <= req.key[KEY_BITS-1:0];
    end
    if (capture) begin
      res <= tail;
    end
    if (commit) begin
      rsp.slot_index <= slot_port(dec_slot);
      rsp.status     <= dec_status;
    end
  end

  // The token reaches the end of the row only during a scan.
  `LKIT_ASSERT_IMP(a_tail_in_scan, tail.valid, state == S_SCAN)
  // A free-slot insert grows the fill count by exactly one.
  `LKIT_ASSERT_NEXT(a_fill_step, commit && dec_status == ST_FREE,
                    slots_filled == $past(slots_filled) + CNT_W'(1))
  // The fill count never passes the table size.
  `LKIT_ASSERT_IMP(a_fill_bound, 1'b1, CMP_W'(slots_filled) <= CMP_W'(ENTRIES))
  // Misses and full results leave the stamp counter alone.
  `LKIT_ASSERT_NEXT(a_stamp_hold, commit && (dec_status == ST_MISS || dec_status == ST_FULL),
                    global_stamp == $past(global_stamp))

endmodule

@@ rtl/core/lru_key_index_table_unit.sv @@
// Key index table with LRU replacement and pinned entries: a row of slot cells.
//
// Usage: req carries mode (0 lookup, 1 define), key and sticky. Each request
// beat produces exactly one rsp beat with slot_index and status (0 hit,
// 1 inserted into a free slot, 2 replaced the least recently used unpinned
// entry, 3 not found, 4 full). cfg writes capacity_in_use; it is ready
// whenever rst is low. The user must write it only while no request is in
// flight; the block does not enforce this.
// Timing: a search token walks the row of ENTRIES cells one cell per cycle.
// When it leaves the last cell, the result is captured and decided; rsp.valid
// and req.ready then rise in the same cycle, and the registered slot update
// lands in the cycle after. A new request is taken only once the last is decided.
// Reset: rst is synchronous; it empties the table, clears all pins and the
// stamp counter, and sets capacity_in_use to 64. No clearing pass is needed.
// Stalls: the response sits in an output register; if rsp.ready stays low,
// the next result waits in the controller and the following request is held.
module lru_key_index_table_unit import lkit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lkit_req_if.sink   req,
  lkit_rsp_if.source rsp,
  lkit_cfg_if.sink   cfg
);

  scan_pkt_t           chain [ENTRIES+1];
  logic [KEY_BITS-1:0] qkey;
  logic [CNT_W-1:0]    slots_filled;
  wr_cmd_t             cmd;

  // Sequencer with the response register and configuration register.
  lkit_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .cfg          (cfg),
    .inject       (chain[0]),
    .tail         (chain[ENTRIES]),
    .qkey         (qkey),
    .slots_filled (slots_filled),
    .cmd          (cmd)
  );

  // Row of slot cells; the search token moves one cell per cycle.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkit_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (SLOT_W'(i)),
      .filled  (slots_filled),
      .qkey    (qkey),
      .cmd     (cmd),
      .pkt_in  (chain[i]),
      .pkt_out (chain[i+1])
    );
  end

endmodule

@@ tb/sv/lru_key_index_table_unit_tb.sv @@
// Testbench for the LRU key index table: directed and random requests against a slot map.
module lru_key_index_table_unit_tb import lkit_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH = 96;
  localparam int PHASE_ITEMS = 180;
  localparam int NUM_PHASES = 9;

  // One expected response beat.
  typedef struct {
    logic [SLOT_PORT_W-1:0] slot;
    status_t                status;
  } slot_result_t;

  // Slot map scoreboard: keeps its own copy of the table and predicts every response.
  class slot_map_board;
    bit [KEY_BITS-1:0] slot_key [ENTRIES];
    bit                slot_pinned [ENTRIES];
    bit [STAMP_W-1:0]  slot_stamp [ENTRIES];
    int unsigned       filled;
    bit [STAMP_W-1:0]  use_count;
    bit [CAP_W-1:0]    capacity;
    slot_result_t      expected_results [$];
    int unsigned       mismatches;

    function new();
      capacity = CAP_RESET;
      filled = 0;
      use_count = '0;
      mismatches = 0;
      foreach (slot_pinned[i]) slot_pinned[i] = 1'b0;
    endfunction

    function void set_capacity(bit [CAP_W-1:0] value);
      capacity = value;
    endfunction

    // Advance the shared counter and stamp the slot with it.
    function void refresh(int unsigned s);
      use_count = use_count + 1'b1;
      slot_stamp[s] = use_count;
    endfunction

    // Predict the response to an accepted request beat and update the table.
    function void note_request(bit is_define, bit [KEY_PORT_W-1:0] key, bit sticky);
      int unsigned       limit;
      int unsigned       hit_slot;
      int unsigned       lru_slot;
      bit                found;
      bit                have_lru;
      bit [STAMP_W-1:0]  lru_stamp;
      bit [KEY_BITS-1:0] k;
      slot_result_t      res;
      k = key[KEY_BITS-1:0];
      limit = (capacity > ENTRIES) ? ENTRIES : capacity;
      found = 1'b0;
      have_lru = 1'b0;
      hit_slot = 0;
      lru_slot = 0;
      lru_stamp = '0;
      // Search the filled slots for the key and the oldest unpinned entry.
      for (int unsigned i = 0; i < filled; i++) begin
        if (!found && slot_key[i] == k) begin
          found = 1'b1;
          hit_slot = i;
        end
        if (!slot_pinned[i] && (!have_lru || slot_stamp[i] < lru_stamp)) begin
          have_lru = 1'b1;
          lru_slot = i;
          lru_stamp = slot_stamp[i];
        end
      end
      res.slot = '0;
      if (found) begin
        if (is_define && sticky) slot_pinned[hit_slot] = 1'b1;
        refresh(hit_slot);
        res.slot = hit_slot[SLOT_PORT_W-1:0];
        res.status = ST_HIT;
      end else if (!is_define) begin
        res.status = ST_MISS;
      end else if (filled < limit) begin
        slot_key[filled] = k;
        slot_pinned[filled] = sticky;
        refresh(filled);
        res.slot = filled[SLOT_PORT_W-1:0];
        res.status = ST_FREE;
        filled++;
      end else if (have_lru) begin
        slot_key[lru_slot] = k;
        slot_pinned[lru_slot] = sticky;
        refresh(lru_slot);
        res.slot = lru_slot[SLOT_PORT_W-1:0];
        res.status = ST_REPLACED;
      end else begin
        res.status = ST_FULL;
      end
      expected_results.push_back(res);
    endfunction

    // Compare a response beat with the oldest prediction, field by field.
    function void check_result(logic [SLOT_PORT_W-1:0] slot, logic [STATUS_W-1:0] status);
      slot_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: response with none pending: slot %0d status %0d", slot, status);
        return;
      end
      want = expected_results.pop_front();
      if (status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status expected %0d got %0d", want.status, status);
      end
      if (slot !== want.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: slot_index expected %0d got %0d", want.slot, slot);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lkit_req_if req_ch ();
  lkit_rsp_if rsp_ch ();
  lkit_cfg_if cfg_ch ();

  lru_key_index_table_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  slot_map_board     table_board = new();
  bit [KEY_PORT_W-1:0] key_pool [POOL_DEPTH];
  bit                sender_gaps = 1'b1;
  int unsigned       items_sent = 0;

  always #2 clk = ~clk;

  // Offer one request beat, after a random gap while gaps are on, and wait until it is taken.
  task automatic send_request(input bit is_define, input bit [KEY_PORT_W-1:0] key,
                              input bit sticky);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.mode   <= is_define;
    req_ch.key    <= key;
    req_ch.sticky <= sticky;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    table_board.note_request(is_define, key, sticky);
    items_sent++;
    if (items_sent % 40 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
  endtask

  // Stop offering and wait until every predicted response has arrived.
  task automatic drain_table();
    req_ch.valid <= 1'b0;
    while (table_board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the capacity register while the table is idle.
  task automatic write_capacity(input bit [CAP_W-1:0] value);
    drain_table();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    table_board.set_capacity(value);
  endtask

  // Response side: random stalls, one long hold-off, and the check of each beat.
  initial begin
    int          gap;
    int unsigned beats;
    bit          gaps_on;
    beats = 0;
    gaps_on = 1'b1;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (beats == 400) gap = 700;
      else gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      table_board.check_result(rsp_ch.slot_index, rsp_ch.status);
      beats++;
      if (beats % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
    end
  end

  // Stimulus: directed corner cases, then random phases at several capacities.
  initial begin
    bit [CAP_W-1:0]      phase_caps [NUM_PHASES];
    bit [KEY_PORT_W-1:0] k;
    bit                  m;
    bit                  s;
    int                  eff_cap;
    int                  pool_size;
    int                  pool_base;
    int                  sticky_odds;
    phase_caps = '{7'd5, 7'd0, 7'd12, 7'd1, 7'd30, 7'd127, 7'd64, 7'd40, 7'd64};
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.mode            <= 1'b0;
    req_ch.key             <= '0;
    req_ch.sticky          <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.capacity_in_use <= '0;
    foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups on the empty table miss, and a sticky lookup pins nothing.
    send_request(1'b0, 64'h0, 1'b1);
    send_request(1'b0, '1, 1'b0);

    // Two slots: fill, hit, replace the oldest, then pin.
    write_capacity(7'd2);
    send_request(1'b1, 64'h0, 1'b0);
    send_request(1'b1, '1, 1'b0);
    send_request(1'b0, '1, 1'b1);
    send_request(1'b1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
    send_request(1'b0, 64'h0, 1'b0);
    send_request(1'b1, '1, 1'b1);
    send_request(1'b1, 64'h0, 1'b0);

    // Capacity zero forces replacement; once all entries are pinned the table is full.
    write_capacity(7'd0);
    send_request(1'b1, 64'h8000_0000_0000_0001, 1'b0);
    send_request(1'b1, 64'h8000_0000_0000_0001, 1'b1);
    send_request(1'b1, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_request(1'b0, 64'h0123_4567_89AB_CDEF, 1'b0);

    // Capacity above the table size acts as the table size.
    write_capacity(7'd127);
    send_request(1'b1, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_request(1'b1, 64'h5555_5555_5555_5555, 1'b0);
    send_request(1'b0, 64'h0123_4567_89AB_CDEF, 1'b1);

    // Random phases: keys mostly from a window a little larger than the capacity.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      eff_cap = (phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
      pool_size = eff_cap + $urandom_range(2, 10);
      if (pool_size > POOL_DEPTH) pool_size = POOL_DEPTH;
      pool_base = $urandom_range(0, POOL_DEPTH - pool_size);
      sticky_odds = (p == NUM_PHASES - 1) ? 6 : 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
        else k = key_pool[pool_base + $urandom_range(0, pool_size - 1)];
        m = ($urandom_range(0, 4) < 3);
        s = m ? ($urandom_range(0, sticky_odds - 1) == 0) : 1'($urandom_range(0, 1));
        send_request(m, k, s);
        // Let the pipeline empty completely once in the middle of the run.
        if (items_sent == 1000) drain_table();
      end
    end

    drain_table();
    repeat (80) @(posedge clk);
    if (table_board.mismatches == 0 && table_board.pending() == 0) begin
      $display("lru_key_index_table_unit test passed");
    end else begin
      $display("lru_key_index_table_unit test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("lru_key_index_table_unit test failed");
    $finish;
  end

endmodule
